[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the heap queue; each use expands to one labeled
// concurrent assertion on clk, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/bmhq_pkg.sv]
// ----------------------------------------------------------------------------
// bmhq_pkg
// Types, sizes and codes shared by the binary min-heap queue modules.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int IDX_W      = ADDR_W + 2;
  localparam int KEY_W      = 16;
  localparam int PAY_W      = 20;
  localparam int COUNT_W    = 11;

  typedef enum logic [0:0] {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [0:0]       action;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]   out_key;
    logic [PAY_W-1:0]   out_payload;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } mem_req_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } fin_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PU_CHK,
    S_PU_CMP,
    S_PO_ROOT,
    S_PO_MOVED,
    S_PO_CHK,
    S_PO_LEFT,
    S_PO_RIGHT
  } state_t;

endpackage

[rtl/bmhq_mem.sv]
// ----------------------------------------------------------------------------
// bmhq_mem
// Heap entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bmhq_mem (
  input  logic              clk,
  input  bmhq_pkg::mem_req_t req,
  output bmhq_pkg::entry_t   rd_data
);
  import bmhq_pkg::*;

  entry_t store_r [HEAP_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      store_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= store_r[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/bmhq_ctrl.sv]
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sift sequencer: walks the heap one level at a time through the store,
// reading, comparing and writing back entries.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  bmhq_pkg::in_item_t in_item,
  input  bmhq_pkg::entry_t   rd_data,
  output logic               busy,
  output bmhq_pkg::mem_req_t mem_req,
  output bmhq_pkg::fin_t     fin
);
  import bmhq_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  entry_t            ent_r, ent_nxt;
  entry_t            left_r, left_nxt;
  entry_t            res_r, res_nxt;
  logic              op_r, op_nxt;

  logic              accept;
  logic              full;
  logic              empty;
  logic [ADDR_W-1:0] parent;
  logic [IDX_W-1:0]  child;
  logic [IDX_W-1:0]  child_r1;
  logic              has_left;
  logic              has_right;
  logic              take_right;
  entry_t            chosen;
  logic [ADDR_W-1:0] chosen_idx;
  logic              stay;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(HEAP_DEPTH));
  assign empty  = (count_r == '0);

  assign parent    = ADDR_W'((pos_r - ADDR_W'(1)) >> 1);
  assign child     = {1'b0, pos_r, 1'b1};
  assign child_r1  = child + IDX_W'(1);
  assign has_left  = (child < IDX_W'(count_r));
  assign has_right = (child_r1 < IDX_W'(count_r));

  // Child selection: the right child wins only when strictly smaller.
  always_comb begin
    take_right = (state_r == S_PO_RIGHT) && (rd_data.key < left_r.key);
    if (state_r == S_PO_RIGHT) begin
      chosen = take_right ? rd_data : left_r;
    end else begin
      chosen = rd_data;
    end
    chosen_idx = take_right ? child_r1[ADDR_W-1:0] : child[ADDR_W-1:0];
    stay       = (ent_r.key <= chosen.key);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.action == ACT_PUSH) begin
            state_nxt = full ? S_IDLE : S_PU_CHK;
          end else begin
            state_nxt = empty ? S_IDLE : S_PO_ROOT;
          end
        end
      end
      S_PU_CHK:   state_nxt = (pos_r == '0) ? S_IDLE : S_PU_CMP;
      S_PU_CMP:   state_nxt = (rd_data.key <= ent_r.key) ? S_IDLE : S_PU_CHK;
      S_PO_ROOT:  state_nxt = S_PO_MOVED;
      S_PO_MOVED: state_nxt = S_PO_CHK;
      S_PO_CHK:   state_nxt = has_left ? S_PO_LEFT : S_IDLE;
      S_PO_LEFT: begin
        if (has_right) begin
          state_nxt = S_PO_RIGHT;
        end else begin
          state_nxt = stay ? S_IDLE : S_PO_CHK;
        end
      end
      S_PO_RIGHT: state_nxt = stay ? S_IDLE : S_PO_CHK;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath, store requests and completion.
  always_comb begin
    count_nxt = count_r;
    pos_nxt   = pos_r;
    ent_nxt   = ent_r;
    left_nxt  = left_r;
    res_nxt   = res_r;
    op_nxt    = op_r;
    mem_req   = '0;
    fin       = '0;
    fin.item.count = COUNT_W'(count_r);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt = in_item.action;
          if (in_item.action == ACT_PUSH) begin
            if (full) begin
              fin.valid       = 1'b1;
              fin.item.status = ST_FULL;
            end else begin
              count_nxt   = count_r + CNT_W'(1);
              pos_nxt     = count_r[ADDR_W-1:0];
              ent_nxt.key     = in_item.key;
              ent_nxt.payload = in_item.payload;
            end
          end else begin
            if (empty) begin
              fin.valid       = 1'b1;
              fin.item.status = ST_EMPTY;
            end else begin
              count_nxt       = count_r - CNT_W'(1);
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = '0;
            end
          end
        end
      end
      S_PU_CHK: begin
        if (pos_r == '0) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pos_r;
          mem_req.wr_data = ent_r;
          fin.valid       = 1'b1;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = parent;
        end
      end
      S_PU_CMP: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pos_r;
        if (rd_data.key <= ent_r.key) begin
          mem_req.wr_data = ent_r;
          fin.valid       = 1'b1;
        end else begin
          mem_req.wr_data = rd_data;
          pos_nxt         = parent;
        end
      end
      S_PO_ROOT: begin
        res_nxt         = rd_data;
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = count_r[ADDR_W-1:0];
      end
      S_PO_MOVED: begin
        ent_nxt = rd_data;
        pos_nxt = '0;
      end
      S_PO_CHK: begin
        if (has_left) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = child[ADDR_W-1:0];
        end else begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pos_r;
          mem_req.wr_data = ent_r;
          fin.valid       = 1'b1;
        end
      end
      S_PO_LEFT, S_PO_RIGHT: begin
        if ((state_r == S_PO_LEFT) && has_right) begin
          left_nxt        = rd_data;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = child_r1[ADDR_W-1:0];
        end else begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pos_r;
          if (stay) begin
            mem_req.wr_data = ent_r;
            fin.valid       = 1'b1;
          end else begin
            mem_req.wr_data = chosen;
            pos_nxt         = chosen_idx;
          end
        end
      end
      default: begin
      end
    endcase

    if (fin.valid && (fin.item.status == ST_OK) && (op_r == ACT_POP)) begin
      fin.item.out_key     = res_r.key;
      fin.item.out_payload = res_r.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    ent_r  <= ent_nxt;
    left_r <= left_nxt;
    res_r  <= res_nxt;
    op_r   <= op_nxt;
  end

endmodule

[rtl/binary_min_heap_queue_top.sv]
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top
// Binary min-heap priority queue of key and payload entries, kept in one
// synchronous single-read, single-write store and sifted level by level.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                      Transfer
//   -------  -------------------------  ---------------------------------------
//   input    start, busy, in_item       item taken when start is high and busy
//                                       is low
//   result   out_valid, out_item        item shown for one cycle while
//                                       out_valid is high
//
// A push climbs the tree level by level, reading each parent and writing one
// entry back per level; a pop reads the root and the last entry, then sinks
// level by level, reading the left and then the right child through the single read port.
// A refused push or pop is reported from idle and leaves the heap unchanged.
// Reset clears the count, the sequencer and the result valid flag; the store is not cleared.
// The receiver cannot stall, and busy is already low while a result is shown.
//
module binary_min_heap_queue_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bmhq_pkg::in_item_t  in_item,
  output logic                out_valid,
  output bmhq_pkg::out_item_t out_item
);
  import bmhq_pkg::*;

`include "assert_macros.svh"

  mem_req_t  mem_req;
  entry_t    rd_data;
  fin_t      fin;
  logic      out_valid_r;
  out_item_t out_item_r;

  // The sequencer owns the entry count and walks the tree.
  bmhq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .rd_data (rd_data),
    .busy    (busy),
    .mem_req (mem_req),
    .fin     (fin)
  );

  // The store holds the heap array itself.
  bmhq_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Result register: each finished item is shown for exactly one cycle, with out_valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.valid) begin
      out_item_r <= fin.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Every accepted item is either still being sifted or already reported.
  `ASSERT_CLK(a_accept_progress, (start && !busy) |=> (busy || out_valid), "item lost after accept")

  // A failed operation never reports an entry.
  `ASSERT_CLK(a_fail_zero, (out_valid && (out_item.status != ST_OK)) |-> ((out_item.out_key == '0) && (out_item.out_payload == '0)), "failed operation reported data")

  // The store is never read and written at the same slot in one cycle.
  `ASSERT_CLK(a_no_rw_clash, (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr), "store read and write collide")

  // The reported count never exceeds the heap capacity.
  `ASSERT_ALWAYS(a_count_cap, out_valid |-> (out_item.count <= COUNT_W'(HEAP_DEPTH)), "count above capacity")

endmodule

[tb/binary_min_heap_queue_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top_tb
// Self-checking bench for the min-heap queue. A behavioral heap predicts each
// result item that a directed row does not write; a directed table runs first,
// then random traffic fills the heap to capacity, drains part, and mixes both.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_top_tb;
  import bmhq_pkg::*;

  // The slowest pop at full depth plus the sender's longest gap stays well
  // below this limit, so reaching it can only mean a hang.
  localparam int STALL_LIMIT  = 1000;
  // Quiet time after the last result, a little over the slowest operation.
  localparam int DRAIN_CYCLES = 48;
  localparam int DIR_N        = 23;

  // One row of the directed table. When typed is set, the wanted result is
  // the one written in the row; otherwise the behavioral heap supplies it.
  typedef struct packed {
    action_t            action;
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;
    logic               typed;
    logic [KEY_W-1:0]   want_key;
    logic [PAY_W-1:0]   want_pay;
    status_t            want_st;
    logic [COUNT_W-1:0] want_cnt;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  binary_min_heap_queue_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Behavioral heap: the bench's own copy of the store and the entry count.
  entry_t      heap_mem [HEAP_DEPTH];
  int unsigned heap_cnt;
  int unsigned peak_cnt;

  // Results still owed by the block, oldest first.
  out_item_t   owed_q [$];

  dir_row_t    dir_tab [DIR_N];

  int          mismatches;
  int          n_items;
  int          n_results;
  int          n_push;
  int          n_pop;
  int          n_full;
  int          n_empty;
  int          idle_cycles;
  bit          no_idle;

  // The clock runs from time zero with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one item to the behavioral heap and return the result item that the
  // block should produce for it. Push sifts up and stops at a parent whose key
  // is less than or equal; pop moves the last entry to the root and sifts it
  // down, choosing the right child only when it is strictly smaller.
  function automatic out_item_t heap_apply(in_item_t it);
    out_item_t   res;
    int unsigned pos;
    int unsigned up;
    int unsigned child;
    entry_t      moved;
    res = '0;
    if (action_t'(it.action) == ACT_PUSH) begin
      if (heap_cnt >= HEAP_DEPTH) begin
        res.status = ST_FULL;
        n_full++;
      end else begin
        pos = heap_cnt;
        heap_cnt++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_mem[up].key <= it.key) break;
          heap_mem[pos] = heap_mem[up];
          pos = up;
        end
        heap_mem[pos].key     = it.key;
        heap_mem[pos].payload = it.payload;
        res.status = ST_OK;
        n_push++;
      end
    end else begin
      if (heap_cnt == 0) begin
        res.status = ST_EMPTY;
        n_empty++;
      end else begin
        res.out_key     = heap_mem[0].key;
        res.out_payload = heap_mem[0].payload;
        heap_cnt--;
        moved = heap_mem[heap_cnt];
        pos   = 0;
        while (pos * 2 + 1 < heap_cnt) begin
          child = pos * 2 + 1;
          if (child + 1 < heap_cnt && heap_mem[child + 1].key < heap_mem[child].key)
            child = child + 1;
          if (moved.key <= heap_mem[child].key) break;
          heap_mem[pos] = heap_mem[child];
          pos = child;
        end
        heap_mem[pos] = moved;
        res.status = ST_OK;
        n_pop++;
      end
    end
    if (heap_cnt > peak_cnt) peak_cnt = heap_cnt;
    res.count = heap_cnt[COUNT_W-1:0];
    return res;
  endfunction

  // Draw a random item; pop_pct is the chance in percent that it is a pop.
  // Keys are sometimes squeezed into a tiny range or onto the extremes so
  // that equal keys, and hence the tie rules of both sifts, come up often.
  // Pops carry random key and payload bits too, which the block must ignore.
  function automatic in_item_t rand_item(int pop_pct);
    in_item_t    it;
    logic [31:0] raw;
    raw        = $urandom;
    it.payload = raw[PAY_W-1:0];
    raw        = $urandom;
    case ($urandom_range(0, 3))
      1: it.key = KEY_W'($urandom_range(0, 15));
      2: begin
        if ($urandom_range(0, 1) == 1) it.key = 16'hFFFF - KEY_W'($urandom_range(0, 1));
        else it.key = KEY_W'($urandom_range(0, 1));
      end
      default: it.key = raw[KEY_W-1:0];
    endcase
    it.action = ($urandom_range(0, 99) < pop_pct) ? ACT_POP : ACT_PUSH;
    return it;
  endfunction

  // Print one line per mismatch and keep count.
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("MISMATCH at %0t, result %0d, %s: got 0x%0h, expected 0x%0h",
             $realtime, n_results, what, got, want);
  endtask

  // Offer one item and wait until the block takes it. Start is left high after
  // acceptance; it only drops when the next item draws a gap, so it is never
  // lowered and raised again within one time step. Busy is sampled at the
  // edge, before the block's own updates for that edge land.
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int        gap;
    out_item_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do begin
      @(posedge clk);
    end while (busy);
    pred = heap_apply(it);
    if (typed) pred = want;
    owed_q = {owed_q, pred};
    n_items++;
    // Every fifty items, decide afresh whether the next stretch runs back to
    // back with no idle cycles at all.
    if (n_items % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
  endtask

  // Result checker. The receiver cannot stall, so every strobe is a result
  // item that must match the oldest one still owed, field by field.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (owed_q.size() == 0) begin
        report_mismatch("result with nothing owed", 32'(out_item.count), 32'(0));
      end else begin
        want = owed_q.pop_front();
        if (out_item.out_key !== want.out_key)
          report_mismatch("out_key", 32'(out_item.out_key), 32'(want.out_key));
        if (out_item.out_payload !== want.out_payload)
          report_mismatch("out_payload", 32'(out_item.out_payload), 32'(want.out_payload));
        if (out_item.status !== want.status)
          report_mismatch("status", 32'(out_item.status), 32'(want.status));
        if (out_item.count !== want.count)
          report_mismatch("count", 32'(out_item.count), 32'(want.count));
      end
    end
  end

  // Watchdog: counts cycles in which no item moves in either direction.
  always @(posedge clk) begin : stall_watch
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles, %0d results still owed",
                 STALL_LIMIT, owed_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    dir_row_t  row;
    in_item_t  it;
    out_item_t want;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    heap_cnt    = 0;
    peak_cnt    = 0;
    mismatches  = 0;
    n_items     = 0;
    n_results   = 0;
    n_push      = 0;
    n_pop       = 0;
    n_full      = 0;
    n_empty     = 0;
    idle_cycles = 0;
    no_idle     = 1'b0;

    // Directed table. The first rows are plain enough to write the answer
    // down: a pop on the empty heap after reset, a push and pop of the
    // all-ones entry, and a pop on empty whose ignored fields are all ones.
    dir_tab[0]  = '{ACT_POP,  16'h0000, 20'h00000, 1'b1, 16'h0000, 20'h00000, ST_EMPTY, 11'd0};
    dir_tab[1]  = '{ACT_PUSH, 16'hFFFF, 20'hFFFFF, 1'b1, 16'h0000, 20'h00000, ST_OK,    11'd1};
    dir_tab[2]  = '{ACT_POP,  16'h0000, 20'h00000, 1'b1, 16'hFFFF, 20'hFFFFF, ST_OK,    11'd0};
    dir_tab[3]  = '{ACT_POP,  16'hFFFF, 20'hFFFFF, 1'b1, 16'h0000, 20'h00000, ST_EMPTY, 11'd0};
    dir_tab[4]  = '{ACT_PUSH, 16'h0000, 20'h00000, 1'b1, 16'h0000, 20'h00000, ST_OK,    11'd1};
    // From here the heap holds several entries, with equal keys at the root
    // and below it, so the order of equal keys on the way out is checked by
    // the behavioral heap.
    dir_tab[5]  = '{ACT_PUSH, 16'h0000, 20'hFFFFF, 1'b0, 16'h0000, 20'h00000, ST_OK,    11'd0};
    dir_tab[6]  = '{ACT_PUSH, 16'h8000, 20'h12345, 1'b0, 16'h0000, 20'h00000, ST_OK,    11'd0};
    dir_tab[7]  = '{ACT_PUSH, 16'h0001, 20'h54321, 1'b0, 16'h0000, 20'h00000, ST_OK,    11'd0};
    dir_tab[8]  = '{ACT_PUSH, 16'hFFFF, 20'h00001, 1'b0, 16'h0000, 20'h00000, ST_OK,    11'd0};
    dir_tab[9]  = '{ACT_PUSH, 16'h0001, 20'hAAAAA, 1'b0, 16'h0000, 20'h00000, ST_OK,    11'd0};
    dir_tab[10] = '{ACT_PUSH, 16'h7FFF, 20'h55555, 1'b0, 16'h0000, 20'h00000, ST_OK,    11'd0};
    dir_tab[11] = '{ACT_PUSH, 16'h0002, 20'h0F0F0, 1'b0, 16'h0000, 20'h00000, ST_OK,    11'd0};
    // Eight pops empty the heap again; the ninth must be refused.
    for (int i = 12; i < 20; i++)
      dir_tab[i] = '{ACT_POP, 16'h0000, 20'h00000, 1'b0, 16'h0000, 20'h00000, ST_OK, 11'd0};
    dir_tab[20] = '{ACT_POP,  16'h0000, 20'h00000, 1'b1, 16'h0000, 20'h00000, ST_EMPTY, 11'd0};
    dir_tab[21] = '{ACT_PUSH, 16'h1234, 20'hF0F0F, 1'b0, 16'h0000, 20'h00000, ST_OK,    11'd0};
    dir_tab[22] = '{ACT_POP,  16'h0000, 20'h00000, 1'b0, 16'h0000, 20'h00000, ST_OK,    11'd0};

    // Reset is held low from time zero and released at a rising edge.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      row              = dir_tab[i];
      it.action        = row.action;
      it.key           = row.key;
      it.payload       = row.payload;
      want.out_key     = row.want_key;
      want.out_payload = row.want_pay;
      want.status      = row.want_st;
      want.count       = row.want_cnt;
      send_item(it, row.typed, want);
    end

    // Balanced traffic keeps the heap shallow and hits the empty case often.
    repeat (100) send_item(rand_item(50), 1'b0, '0);

    // Pushes only until the heap is full, then a stretch at capacity where
    // refused pushes mix with the odd pop that makes room again.
    while (heap_cnt < HEAP_DEPTH) send_item(rand_item(0), 1'b0, '0);
    repeat (16) send_item(rand_item(20), 1'b0, '0);

    // A run of pops from the deep heap: long sift-downs.
    repeat (250) send_item(rand_item(100), 1'b0, '0);

    // A last mixed stretch, slightly in favor of pushes.
    repeat (90) send_item(rand_item(45), 1'b0, '0);

    start <= 1'b0;

    // Wait for every owed result, then leave room for any stray strobe.
    while (owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items: %0d pushes, %0d pops, %0d refused when full, %0d refused when empty",
             n_items, n_push, n_pop, n_full, n_empty);
    $display("Checked %0d result items; the heap reached %0d of %0d entries",
             n_results, peak_cnt, HEAP_DEPTH);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[binary_min_heap_queue_top.f]
+incdir+rtl
rtl/bmhq_pkg.sv
rtl/bmhq_mem.sv
rtl/bmhq_ctrl.sv
rtl/binary_min_heap_queue_top.sv
tb/binary_min_heap_queue_top_tb.sv
